### rtl/qp_pkg.sv
// Package for the urlencoded query parser.
// Holds character codes, the size default and the hex digit decoder.
// No dependencies.
package qp_pkg;

    // Default segment buffer depth in bytes
    localparam int SEG_BYTES_DEF = 64;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Escape radix is 16, so one hex digit is one nibble
    localparam int HEX_RADIX = 16;
    localparam int NIB_W     = $clog2(HEX_RADIX);

    typedef struct packed {
        logic             ok;
        logic [NIB_W-1:0] dig;
    } t_hex;

    // Map an ASCII character to its hex digit value, case-insensitive
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            r.ok = 1'b1;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            r.ok = 1'b1;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            r.ok = 1'b1;
        end
        r.dig = d[NIB_W-1:0];
        return r;
    endfunction

endpackage

### rtl/qp_if.sv
// Valid/ready channel interfaces of the urlencoded query parser.
// Input word: one query byte; output word: one decoded byte or marker.
// No dependencies.
interface qp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_query;

    modport source (output valid, output in_byte, output end_of_query, input ready);
    modport sink   (input valid, input in_byte, input end_of_query, output ready);
endinterface

interface qp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       is_value;
    logic       status;
    logic       last;

    modport source (output valid, output out_byte, output byte_valid, output is_value,
                    output status, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input is_value,
                    input status, input last, output ready);
endinterface

### rtl/qp_store.sv
// Segment byte store: one write port, one registered read port.
// Depends on qp_pkg for the default depth.
module qp_store #(
    parameter int  SEG_BYTES = qp_pkg::SEG_BYTES_DEF,
    localparam int AW        = $clog2(SEG_BYTES)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);
    import qp_pkg::*;

    logic [7:0] r_mem [SEG_BYTES];
    logic [7:0] r_rd_data;

    // Write incoming bytes, register the read word; hold it while not reading
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/qp_decode.sv
// Decode sequencer: walks the stored segment one byte per read, runs the
// shared character/hex classifier and loads the output word register.
// Depends on qp_pkg and qp_if.
module qp_decode #(
    parameter int  SEG_BYTES = qp_pkg::SEG_BYTES_DEF,
    localparam int AW        = $clog2(SEG_BYTES),
    localparam int LW        = $clog2(SEG_BYTES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_ovf,
    input  logic [LW-1:0] i_len,
    input  logic [AW-1:0] i_eq,
    output logic          o_idle,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data,
    qp_out_if.source      o_out
);
    import qp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_CHAR = 6'b000100,
        S_HEX0 = 6'b001000,
        S_HEX1 = 6'b010000,
        S_MARK = 6'b100000
    } t_dec_state;

    t_dec_state       r_state, n_state;
    logic [LW-1:0]    r_pos, n_pos;
    logic [LW-1:0]    r_end, n_end;
    logic [LW-1:0]    r_len, n_len;
    logic [AW-1:0]    r_eq, n_eq;
    logic             r_isval, n_isval;
    logic             r_ovf, n_ovf;
    logic [NIB_W-1:0] r_d0, n_d0;
    logic             r_d0ok, n_d0ok;

    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_obv, r_oisval, r_ostat, r_olast;

    logic             slot_free;
    logic             ld;
    logic [7:0]       ld_byte;
    logic             ld_bv, ld_stat, ld_last;
    t_hex             hx;
    logic [7:0]       esc_val;

    assign slot_free = !r_ovalid || o_out.ready;
    assign hx        = hex_decode(i_rd_data);
    // Two digits give d0*16+d1, a lone digit gives d0
    assign esc_val   = hx.ok ? {r_d0, hx.dig} : {{(8-NIB_W){1'b0}}, r_d0};

    // Sequence the walk over name part, value part and the closing marker
    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_end   = r_end;
        n_len   = r_len;
        n_eq    = r_eq;
        n_isval = r_isval;
        n_ovf   = r_ovf;
        n_d0    = r_d0;
        n_d0ok  = r_d0ok;
        o_rd_en   = 1'b0;
        o_rd_addr = r_pos[AW-1:0];
        ld      = 1'b0;
        ld_byte = CH_NUL;
        ld_bv   = 1'b0;
        ld_stat = 1'b0;
        ld_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_ovf   = i_ovf;
                    n_len   = i_len;
                    n_eq    = i_eq;
                    n_pos   = '0;
                    n_end   = LW'(i_eq);
                    n_isval = 1'b0;
                    n_state = i_ovf ? S_MARK : S_READ;
                end
            end
            S_READ: begin
                if (r_pos >= r_end) begin
                    // Part done: switch to the value, or close the pair
                    if (!r_isval) begin
                        n_pos   = LW'(r_eq) + LW'(1);
                        n_end   = r_len;
                        n_isval = 1'b1;
                    end else begin
                        n_state = S_MARK;
                    end
                end else begin
                    o_rd_en = 1'b1;
                    n_pos   = r_pos + LW'(1);
                    n_state = S_CHAR;
                end
            end
            S_CHAR: begin
                if (i_rd_data == CH_PCT) begin
                    if ((r_end - r_pos) < LW'(2)) begin
                        // Truncated escape ends this part
                        n_pos   = r_end;
                        n_state = S_READ;
                    end else begin
                        o_rd_en = 1'b1;
                        n_pos   = r_pos + LW'(1);
                        n_state = S_HEX0;
                    end
                end else if (slot_free) begin
                    ld      = 1'b1;
                    ld_byte = (i_rd_data == CH_PLUS) ? CH_SPACE : i_rd_data;
                    ld_bv   = 1'b1;
                    n_state = S_READ;
                end
            end
            S_HEX0: begin
                n_d0    = hx.dig;
                n_d0ok  = hx.ok;
                o_rd_en = 1'b1;
                n_pos   = r_pos + LW'(1);
                n_state = S_HEX1;
            end
            S_HEX1: begin
                // Drop non-hex leads and zero results
                if (!r_d0ok || esc_val == CH_NUL) begin
                    n_state = S_READ;
                end else if (slot_free) begin
                    ld      = 1'b1;
                    ld_byte = esc_val;
                    ld_bv   = 1'b1;
                    n_state = S_READ;
                end
            end
            S_MARK: begin
                if (slot_free) begin
                    ld      = 1'b1;
                    ld_stat = r_ovf;
                    ld_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_pos   <= n_pos;
        r_end   <= n_end;
        r_len   <= n_len;
        r_eq    <= n_eq;
        r_isval <= n_isval;
        r_ovf   <= n_ovf;
        r_d0    <= n_d0;
        r_d0ok  <= n_d0ok;
    end

    // Output word register: load a new word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ld) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (ld) begin
            r_obyte  <= ld_byte;
            r_obv    <= ld_bv;
            r_oisval <= ld_bv & r_isval;
            r_ostat  <= ld_stat;
            r_olast  <= ld_last;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.out_byte   = r_obyte;
    assign o_out.byte_valid = r_obv;
    assign o_out.is_value   = r_oisval;
    assign o_out.status     = r_ostat;
    assign o_out.last       = r_olast;
    assign o_idle           = (r_state == S_IDLE);

    // A read never goes past the end of the current part
    a_rd_in_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (r_pos < r_end))
        else $error("store read beyond end of part");

    // A new segment is only handed over while the sequencer is idle
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("segment start while decoding");

    // Decoded bytes are never zero
    a_no_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.byte_valid) |-> (o_out.out_byte != CH_NUL))
        else $error("zero byte emitted");

    // Overflow word is always a closing marker without a byte
    a_ovf_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> (o_out.last && !o_out.byte_valid))
        else $error("malformed overflow marker");

endmodule

### rtl/urlencoded_query_parser.sv
// Input: one query byte per cycle into the segment store while the sequencer is idle.
// On a terminator or end of query that closes a kept pair or an overflowed segment, the
// sequencer walks the segment: each plain byte is read and loaded as one output word, an
// escape reads '%' and two hex digits, a truncated '%' ends its part, then the parts are
// closed and the marker is loaded (only the marker on overflow); input is not ready
// meanwhile. Synchronous reset clears control state; the store needs no clearing pass.
module urlencoded_query_parser #(
    parameter int  SEG_BYTES = qp_pkg::SEG_BYTES_DEF,
    localparam int AW        = $clog2(SEG_BYTES),
    localparam int LW        = $clog2(SEG_BYTES + 1)
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qp_in_if.sink    i_in,
    qp_out_if.source o_out
);
    import qp_pkg::*;

    logic [LW-1:0] r_len, n_len;
    logic [AW-1:0] r_eq, n_eq;
    logic          r_seen, n_seen;
    logic          r_ovf, n_ovf;

    logic          idle;
    logic          acc;
    logic          term;
    logic          full;
    logic          wr_en;
    logic [LW-1:0] len_a;
    logic [AW-1:0] eq_a;
    logic          seen_a;
    logic          ovf_a;
    logic          close_seg;
    logic          pair_ok;
    logic          start;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign i_in.ready = idle;
    assign acc        = i_in.valid && idle;
    assign term       = (i_in.in_byte == CH_NUL) || (i_in.in_byte == CH_AMP);
    assign full       = (r_len == LW'(SEG_BYTES));
    assign wr_en      = acc && !term && !full;

    // Segment state after this word is taken in
    assign len_a  = wr_en ? (r_len + LW'(1)) : r_len;
    assign eq_a   = (wr_en && i_in.in_byte == CH_EQ) ? r_len[AW-1:0] : r_eq;
    assign seen_a = r_seen || (wr_en && i_in.in_byte == CH_EQ);
    assign ovf_a  = r_ovf || (!term && full);

    assign close_seg = acc && (term || i_in.end_of_query);
    assign pair_ok   = seen_a && (eq_a != '0) && (len_a > (LW'(eq_a) + LW'(1)));
    assign start     = close_seg && (ovf_a || pair_ok);

    // Track the open segment; clear it when it closes
    always_comb begin
        n_len  = r_len;
        n_eq   = r_eq;
        n_seen = r_seen;
        n_ovf  = r_ovf;
        if (close_seg) begin
            n_len  = '0;
            n_eq   = '0;
            n_seen = 1'b0;
            n_ovf  = 1'b0;
        end else if (acc) begin
            n_len  = len_a;
            n_eq   = eq_a;
            n_seen = seen_a;
            n_ovf  = ovf_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_eq   <= '0;
            r_seen <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_eq   <= n_eq;
            r_seen <= n_seen;
            r_ovf  <= n_ovf;
        end
    end

    qp_store #(
        .SEG_BYTES (SEG_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_len[AW-1:0]),
        .i_wr_data (i_in.in_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    qp_decode #(
        .SEG_BYTES (SEG_BYTES)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_ovf     (ovf_a),
        .i_len     (len_a),
        .i_eq      (eq_a),
        .o_idle    (idle),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_out     (o_out)
    );

endmodule
